### rtl/core/range_scan_occupancy_grid_unit_assert.svh
// Assertion macros shared by the occupancy grid unit.
`ifndef RANGE_SCAN_OCCUPANCY_GRID_UNIT_ASSERT_SVH
`define RANGE_SCAN_OCCUPANCY_GRID_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled during reset.
`define RSOG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset.
`define RSOG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define RSOG_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define RSOG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### rtl/core/rsog_pkg.sv
// Shared types, codes and constants of the occupancy grid unit.
`default_nettype none
package rsog_pkg;

    // Input function codes.
    localparam logic [1:0] FUNC_CLEAR = 2'd0;
    localparam logic [1:0] FUNC_SCAN  = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [2:0] REG_SENSOR_X = 3'd0;
    localparam logic [2:0] REG_SENSOR_Y = 3'd1;
    localparam logic [2:0] REG_START    = 3'd2;
    localparam logic [2:0] REG_INC      = 3'd3;
    localparam logic [2:0] REG_WIDTH    = 3'd4;
    localparam logic [2:0] REG_HEIGHT   = 3'd5;

    localparam logic [15:0] SPAN_RESET = 16'd1000;

    // CORDIC setup.
    localparam logic [3:0]         CORDIC_LAST = 4'd13;
    localparam logic signed [17:0] CORDIC_X0   = 18'sd19898;

    // Width of the node divider's working remainder.
    localparam int DIVW = 29;

    // Commands passed from the front to the back.
    typedef enum logic [1:0] {
        OP_NOP,
        OP_CLEAR,
        OP_READ,
        OP_PAINT
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] cx;
        logic [7:0] cy;
    } t_cmd;

    typedef enum logic [3:0] {
        FE_IDLE,
        FE_ANGLE,
        FE_CORDIC,
        FE_SAT,
        FE_MUL,
        FE_POS,
        FE_NUM,
        FE_DSET,
        FE_DIV,
        FE_PUSH
    } t_fe_state;

    typedef enum logic [2:0] {
        BE_CLEAR,
        BE_IDLE,
        BE_RD,
        BE_WR,
        BE_RES,
        BE_EMIT
    } t_be_state;

    // Arctangent of 2^-i in 1/65536 turn.
    function automatic logic signed [17:0] atan_turn(input logic [3:0] idx);
        logic signed [17:0] v;
        case (idx)
            4'd0:    v = 18'sd8192;
            4'd1:    v = 18'sd4836;
            4'd2:    v = 18'sd2555;
            4'd3:    v = 18'sd1297;
            4'd4:    v = 18'sd651;
            4'd5:    v = 18'sd326;
            4'd6:    v = 18'sd163;
            4'd7:    v = 18'sd81;
            4'd8:    v = 18'sd41;
            4'd9:    v = 18'sd20;
            4'd10:   v = 18'sd10;
            4'd11:   v = 18'sd5;
            4'd12:   v = 18'sd3;
            4'd13:   v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

### rtl/core/range_scan_occupancy_grid_unit.sv
// A scan point runs through the front (CORDIC rotations, then the node divide) and then the
// back (a read and a write per in-grid cell of the 3x3 neighborhood).
// The front takes no new beat while its sequencer is still busy with the last one.
// A clear writes one memory word per cycle across all GRID_X*GRID_Y words.
// Reset is synchronous; after it the same clearing sweep runs and no beat is taken until done.
`default_nettype none
module range_scan_occupancy_grid_unit import rsog_pkg::*; #(
    parameter int GRID_X = 64,
    parameter int GRID_Y = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_func,
    input  wire logic [15:0] i_distance_mm,
    input  wire logic [10:0] i_step_index,
    input  wire logic [7:0]  i_read_x,
    input  wire logic [7:0]  i_read_y,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_cell_value,
    output logic             o_in_grid,
    output logic [7:0]       o_node_x,
    output logic [7:0]       o_node_y
);

    `include "range_scan_occupancy_grid_unit_assert.svh"

    logic [15:0] r_sensor_x, r_sensor_y, r_start, r_inc, r_width, r_height;
    logic        fe_busy, init_busy;
    logic        fq_valid, fq_stall, qb_valid, qb_stall;
    t_cmd        fq_cmd, qb_cmd;

    assign o_in_stall = fe_busy || init_busy;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sensor_x <= 16'd0;
            r_sensor_y <= 16'd0;
            r_start    <= 16'd0;
            r_inc      <= 16'd0;
            r_width    <= SPAN_RESET;
            r_height   <= SPAN_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SENSOR_X: r_sensor_x <= i_cfg_data;
                REG_SENSOR_Y: r_sensor_y <= i_cfg_data;
                REG_START:    r_start    <= i_cfg_data;
                REG_INC:      r_inc      <= i_cfg_data;
                REG_WIDTH:    r_width    <= i_cfg_data;
                REG_HEIGHT:   r_height   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rsog_front #(.GRID_X(GRID_X), .GRID_Y(GRID_Y)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_hold       (init_busy),
        .i_valid      (i_in_valid),
        .o_busy       (fe_busy),
        .i_func       (i_func),
        .i_distance_mm(i_distance_mm),
        .i_step_index (i_step_index),
        .i_read_x     (i_read_x),
        .i_read_y     (i_read_y),
        .i_sensor_x   (r_sensor_x),
        .i_sensor_y   (r_sensor_y),
        .i_start      (r_start),
        .i_inc        (r_inc),
        .i_width      (r_width),
        .i_height     (r_height),
        .o_cmd_valid  (fq_valid),
        .o_cmd        (fq_cmd),
        .i_cmd_stall  (fq_stall)
    );

    rsog_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(fq_valid),
        .o_stall(fq_stall),
        .i_cmd  (fq_cmd),
        .o_valid(qb_valid),
        .i_stall(qb_stall),
        .o_cmd  (qb_cmd)
    );

    rsog_back #(.GRID_X(GRID_X), .GRID_Y(GRID_Y)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (qb_valid),
        .o_cmd_stall (qb_stall),
        .i_cmd       (qb_cmd),
        .o_init_busy (init_busy),
        .o_valid     (o_out_valid),
        .i_stall     (i_out_stall),
        .o_cell_value(o_cell_value),
        .o_in_grid   (o_in_grid),
        .o_node_x    (o_node_x),
        .o_node_y    (o_node_y)
    );

    // A painted center cell is always at least 191 after brightening.
    `RSOG_ASSERT_IMPL(a_paint_bright, i_clk, i_rst_n, o_out_valid && o_in_grid, o_cell_value >= 8'd191, "painted cell too dark")
    // A mapped node lies inside the grid.
    `RSOG_ASSERT_IMPL(a_node_range, i_clk, i_rst_n, o_out_valid && o_in_grid, ({1'b0, o_node_x} < 9'(GRID_X)) && ({1'b0, o_node_y} < 9'(GRID_Y)), "node outside grid")
    // Unmapped results carry zero coordinates.
    `RSOG_ASSERT_IMPL(a_zero_node, i_clk, i_rst_n, o_out_valid && !o_in_grid, o_node_x == 8'd0 && o_node_y == 8'd0, "stray node coordinates")
    // No beat is taken during the clearing sweep after reset.
    `RSOG_ASSERT_NEXT(a_init_hold, i_clk, i_rst_n, init_busy, o_in_stall || !init_busy, "beat taken during sweep")

endmodule
`default_nettype wire

### rtl/core/rsog_front.sv
// Front end: accepts beats, classifies them and maps scan points to grid nodes.
`default_nettype none
module rsog_front import rsog_pkg::*; #(
    parameter int GRID_X = 64,
    parameter int GRID_Y = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_hold,
    input  wire logic        i_valid,
    output logic             o_busy,
    input  wire logic [1:0]  i_func,
    input  wire logic [15:0] i_distance_mm,
    input  wire logic [10:0] i_step_index,
    input  wire logic [7:0]  i_read_x,
    input  wire logic [7:0]  i_read_y,
    input  wire logic [15:0] i_sensor_x,
    input  wire logic [15:0] i_sensor_y,
    input  wire logic [15:0] i_start,
    input  wire logic [15:0] i_inc,
    input  wire logic [15:0] i_width,
    input  wire logic [15:0] i_height,
    output logic             o_cmd_valid,
    output t_cmd             o_cmd,
    input  wire logic        i_cmd_stall
);

    localparam logic [8:0]        GX9  = 9'(GRID_X);
    localparam logic [8:0]        GY9  = 9'(GRID_Y);
    localparam logic signed [9:0] GXM1 = 10'(GRID_X - 1);
    localparam logic signed [9:0] GYM1 = 10'(GRID_Y - 1);

    t_fe_state r_state, n_state;

    logic               r_func_scan;
    logic [15:0]        r_dist;
    logic [10:0]        r_step;
    t_cmd               r_cmd;
    logic signed [17:0] r_x, r_y, r_z;
    logic               r_neg;
    logic [3:0]         r_iter;
    logic signed [15:0] r_cos, r_sin;
    logic signed [32:0] r_prodx, r_prody;
    logic signed [17:0] r_px, r_py;
    logic signed [27:0] r_numx, r_numy;
    logic [DIVW-1:0]    r_remx, r_remy;
    logic [16:0]        r_tsx, r_tsy;
    logic               r_okx, r_oky;
    logic [7:0]         r_qx, r_qy;
    logic [2:0]         r_bit;

    logic               accept;
    logic [26:0]        ang_prod;
    logic signed [17:0] ang_ext;
    logic signed [17:0] dx, dy, atan_v;
    logic signed [17:0] xv, yv;
    logic signed [33:0] rndx, rndy;
    logic               negx, negy;
    logic [27:0]        absx, absy;
    logic [16:0]        tsx, tsy;
    logic [DIVW-1:0]    divx, divy, limx, limy, trialx, trialy;

    assign accept      = (r_state == FE_IDLE) && i_valid && !i_hold;
    assign o_busy      = (r_state != FE_IDLE);
    assign o_cmd_valid = (r_state == FE_PUSH) && !r_func_scan;
    assign o_cmd       = r_cmd;

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FE_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            FE_IDLE:   if (accept) n_state = (i_func == FUNC_SCAN) ? FE_ANGLE : FE_PUSH;
            FE_ANGLE:  n_state = FE_CORDIC;
            FE_CORDIC: if (r_iter == CORDIC_LAST) n_state = FE_SAT;
            FE_SAT:    n_state = FE_MUL;
            FE_MUL:    n_state = FE_POS;
            FE_POS:    n_state = FE_NUM;
            FE_NUM:    n_state = FE_DSET;
            FE_DSET:   n_state = FE_DIV;
            FE_DIV:    if (r_bit == 3'd0) n_state = FE_PUSH;
            FE_PUSH:   if (o_cmd_valid && !i_cmd_stall) n_state = FE_IDLE;
            default:   n_state = FE_IDLE;
        endcase
    end

    // Scan angle: start plus step index times increment.
    always_comb begin
        ang_prod = 27'(r_step) * 27'(i_inc);
        ang_ext  = 18'($signed(i_start + ang_prod[15:0]));
    end

    // One CORDIC rotation; shifts floor toward minus infinity.
    always_comb begin
        dx     = r_y >>> r_iter;
        dy     = r_x >>> r_iter;
        atan_v = atan_turn(r_iter);
        xv     = r_neg ? -r_x : r_x;
        yv     = r_neg ? -r_y : r_y;
    end

    // Rounded position and node divider setup.
    always_comb begin
        rndx   = 34'(r_prodx) + 34'sd16384;
        rndy   = 34'(r_prody) + 34'sd16384;
        negx   = r_numx[27];
        negy   = r_numy[27];
        absx   = negx ? 28'(-r_numx) : 28'(r_numx);
        absy   = negy ? 28'(-r_numy) : 28'(r_numy);
        tsx    = {i_width, 1'b0};
        tsy    = {i_height, 1'b0};
        divx   = DIVW'({absx, 1'b0}) + DIVW'(i_width);
        divy   = DIVW'({absy, 1'b0}) + DIVW'(i_height);
        limx   = DIVW'(GX9) * DIVW'(tsx);
        limy   = DIVW'(GY9) * DIVW'(tsy);
        trialx = DIVW'(r_tsx) << r_bit;
        trialy = DIVW'(r_tsy) << r_bit;
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            FE_IDLE: begin
                r_dist      <= i_distance_mm;
                r_step      <= i_step_index;
                r_func_scan <= (i_func == FUNC_SCAN);
                r_cmd.cx    <= i_read_x;
                r_cmd.cy    <= i_read_y;
                if (i_func == FUNC_CLEAR) begin
                    r_cmd.op <= OP_CLEAR;
                end else if (i_func == FUNC_READ && {1'b0, i_read_x} < GX9
                             && {1'b0, i_read_y} < GY9) begin
                    r_cmd.op <= OP_READ;
                end else begin
                    r_cmd.op <= OP_NOP;
                end
            end
            FE_ANGLE: begin
                r_x    <= CORDIC_X0;
                r_y    <= 18'sd0;
                r_iter <= 4'd0;
                if (ang_ext > 18'sd16384) begin
                    r_z   <= ang_ext - 18'sd32768;
                    r_neg <= 1'b1;
                end else if (ang_ext < -18'sd16384) begin
                    r_z   <= ang_ext + 18'sd32768;
                    r_neg <= 1'b1;
                end else begin
                    r_z   <= ang_ext;
                    r_neg <= 1'b0;
                end
            end
            FE_CORDIC: begin
                r_iter <= r_iter + 4'd1;
                if (r_z >= 18'sd0) begin
                    r_x <= r_x - dx;
                    r_y <= r_y + dy;
                    r_z <= r_z - atan_v;
                end else begin
                    r_x <= r_x + dx;
                    r_y <= r_y - dy;
                    r_z <= r_z + atan_v;
                end
            end
            FE_SAT: begin
                if (xv > 18'sd32767)       r_cos <= 16'sd32767;
                else if (xv < -18'sd32767) r_cos <= -16'sd32767;
                else                       r_cos <= xv[15:0];
                if (yv > 18'sd32767)       r_sin <= 16'sd32767;
                else if (yv < -18'sd32767) r_sin <= -16'sd32767;
                else                       r_sin <= yv[15:0];
            end
            FE_MUL: begin
                r_prodx <= r_cos * $signed({1'b0, r_dist});
                r_prody <= r_sin * $signed({1'b0, r_dist});
            end
            FE_POS: begin
                r_px <= 18'($signed(i_sensor_x)) + $signed(rndx[32:15]);
                r_py <= 18'($signed(i_sensor_y)) + $signed(rndy[32:15]);
            end
            FE_NUM: begin
                r_numx <= r_px * GXM1;
                r_numy <= r_py * GYM1;
            end
            FE_DSET: begin
                r_remx <= divx;
                r_remy <= divy;
                r_tsx  <= tsx;
                r_tsy  <= tsy;
                r_bit  <= 3'd7;
                r_okx  <= (i_width != 16'd0) && (negx ? divx < DIVW'(tsx) : divx < limx);
                r_oky  <= (i_height != 16'd0) && (negy ? divy < DIVW'(tsy) : divy < limy);
            end
            FE_DIV: begin
                // One quotient bit per axis per cycle, most significant first.
                r_bit <= r_bit - 3'd1;
                if (r_remx >= trialx) begin
                    r_remx      <= r_remx - trialx;
                    r_qx[r_bit] <= 1'b1;
                end else begin
                    r_qx[r_bit] <= 1'b0;
                end
                if (r_remy >= trialy) begin
                    r_remy      <= r_remy - trialy;
                    r_qy[r_bit] <= 1'b1;
                end else begin
                    r_qy[r_bit] <= 1'b0;
                end
            end
            FE_PUSH: begin
                // Scan points resolve to a paint or a no-op here, in the cycle before the command is offered.
                if (r_func_scan) begin
                    r_func_scan <= 1'b0;
                    r_cmd.op    <= (r_okx && r_oky) ? OP_PAINT : OP_NOP;
                    r_cmd.cx    <= r_qx;
                    r_cmd.cy    <= r_qy;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

### rtl/core/rsog_queue.sv
// Two-entry command queue between the front and back ends.
`default_nettype none
module rsog_queue import rsog_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  t_cmd      i_cmd,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_cmd      o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_stall = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rd];
    assign push    = i_valid && !o_stall;
    assign pop     = o_valid && !i_stall;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wr] <= i_cmd;
    end

endmodule
`default_nettype wire

### rtl/core/rsog_back.sv
// Back end: grid memory, clearing sweep, neighborhood brightening and result register.
`default_nettype none
module rsog_back import rsog_pkg::*; #(
    parameter int GRID_X = 64,
    parameter int GRID_Y = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_valid,
    output logic      o_cmd_stall,
    input  t_cmd      i_cmd,
    output logic      o_init_busy,
    output logic      o_valid,
    input  wire logic i_stall,
    output logic [7:0] o_cell_value,
    output logic      o_in_grid,
    output logic [7:0] o_node_x,
    output logic [7:0] o_node_y
);

    localparam int         DEPTH = GRID_X * GRID_Y;
    localparam int         AW    = $clog2(DEPTH);
    localparam logic [9:0] GX10  = 10'(GRID_X);
    localparam logic [9:0] GY10  = 10'(GRID_Y);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    t_be_state r_state, n_state;

    logic [7:0]    r_grid [DEPTH];
    logic [7:0]    r_rdata;
    t_cmd          r_cmd;
    logic [1:0]    r_kx, r_ky;
    logic [AW-1:0] r_clr_addr;
    logic          r_init, r_clr_cmd;
    logic [7:0]    r_res;

    logic [9:0]    nx, ny;
    logic          nb_in;
    logic [AW-1:0] nb_addr, mem_addr;
    logic          mem_we;
    logic [7:0]    mem_wdata, bright;
    logic [9:0]    bright_sum;
    logic          last_nb, take, out_free;

    assign o_init_busy = r_init;
    assign o_cmd_stall = (r_state != BE_IDLE);
    assign take        = (r_state == BE_IDLE) && i_cmd_valid;
    assign out_free    = !o_valid || !i_stall;

    // Neighbor coordinates, offset by one so that a column of minus one is zero.
    always_comb begin
        nx         = {2'b0, r_cmd.cx} + {8'b0, r_kx};
        ny         = {2'b0, r_cmd.cy} + {8'b0, r_ky};
        nb_in      = (nx != 10'd0) && (nx <= GX10) && (ny != 10'd0) && (ny <= GY10);
        nb_addr    = AW'(32'(ny - 10'd1) * GRID_X + 32'(nx - 10'd1));
        last_nb    = (r_kx == 2'd2) && (r_ky == 2'd2);
        bright_sum = {2'b0, r_rdata} + 10'd765;
        bright     = bright_sum[9:2];
    end

    // Memory port control.
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = bright;
        mem_addr  = nb_addr;
        case (r_state)
            BE_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = 8'd0;
                mem_addr  = r_clr_addr;
            end
            BE_WR:   mem_we = 1'b1;
            default: mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) r_grid[mem_addr] <= mem_wdata;
        r_rdata <= r_grid[mem_addr];
    end

    // Sequencer state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BE_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            BE_CLEAR: if (r_clr_addr == LAST_ADDR) n_state = r_clr_cmd ? BE_EMIT : BE_IDLE;
            BE_IDLE: begin
                if (take) begin
                    case (i_cmd.op)
                        OP_CLEAR: n_state = BE_CLEAR;
                        OP_READ:  n_state = BE_RD;
                        OP_PAINT: n_state = BE_RD;
                        default:  n_state = BE_EMIT;
                    endcase
                end
            end
            BE_RD: begin
                if (r_cmd.op == OP_READ)  n_state = BE_RES;
                else if (nb_in)           n_state = BE_WR;
                else if (last_nb)         n_state = BE_EMIT;
            end
            BE_WR:   n_state = last_nb ? BE_EMIT : BE_RD;
            BE_RES:  n_state = BE_EMIT;
            BE_EMIT: if (out_free) n_state = BE_IDLE;
            default: n_state = BE_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init     <= 1'b1;
            r_clr_cmd  <= 1'b0;
            r_clr_addr <= '0;
            o_valid    <= 1'b0;
        end else begin
            // A new result loads the output register; an accepted one empties it.
            if (r_state == BE_EMIT && out_free) begin
                o_valid <= 1'b1;
            end else if (!i_stall) begin
                o_valid <= 1'b0;
            end
            case (r_state)
                BE_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_init     <= 1'b0;
                        r_clr_addr <= '0;
                    end
                end
                BE_IDLE: if (take) r_clr_cmd <= (i_cmd.op == OP_CLEAR);
                default: begin
                end
            endcase
        end
    end

    // Command, neighbor walk and result payload.
    always_ff @(posedge i_clk) begin
        case (r_state)
            BE_IDLE: begin
                r_cmd <= i_cmd;
                r_res <= 8'd0;
                r_kx  <= (i_cmd.op == OP_READ) ? 2'd1 : 2'd0;
                r_ky  <= (i_cmd.op == OP_READ) ? 2'd1 : 2'd0;
            end
            BE_RD: begin
                if (r_cmd.op != OP_READ && !nb_in) begin
                    r_kx <= (r_kx == 2'd2) ? 2'd0 : r_kx + 2'd1;
                    if (r_kx == 2'd2) r_ky <= r_ky + 2'd1;
                end
            end
            BE_WR: begin
                if (r_kx == 2'd1 && r_ky == 2'd1) r_res <= bright;
                r_kx <= (r_kx == 2'd2) ? 2'd0 : r_kx + 2'd1;
                if (r_kx == 2'd2) r_ky <= r_ky + 2'd1;
            end
            BE_RES: r_res <= r_rdata;
            BE_EMIT: begin
                if (out_free) begin
                    o_cell_value <= (r_cmd.op == OP_READ || r_cmd.op == OP_PAINT)
                                    ? r_res : 8'd0;
                    o_in_grid    <= (r_cmd.op == OP_PAINT);
                    o_node_x     <= (r_cmd.op == OP_PAINT) ? r_cmd.cx : 8'd0;
                    o_node_y     <= (r_cmd.op == OP_PAINT) ? r_cmd.cy : 8'd0;
                end
            end
            default: begin
            end
        endcase
    end

endmodule
`default_nettype wire

### tb/occupancy_grid_checker.sv
// Checker that predicts and compares the results of the occupancy grid unit.
module occupancy_grid_checker import rsog_pkg::*; #(
    parameter int GRID_X = 64,
    parameter int GRID_Y = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_distance_mm,
    input  logic [10:0] i_step_index,
    input  logic [7:0]  i_read_x,
    input  logic [7:0]  i_read_y,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_cell_value,
    input  logic        i_in_grid,
    input  logic [7:0]  i_node_x,
    input  logic [7:0]  i_node_y,
    output int          o_errors,
    output int          o_pending,
    output int          o_hits
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] value;
        logic       hit;
        logic [7:0] nx;
        logic [7:0] ny;
    } t_grid_result;

    t_grid_result     result_queue[$];
    logic [7:0]       occupancy[GRID_X*GRID_Y];
    logic signed [15:0] pos_x_reg, pos_y_reg;
    logic [15:0]      start_reg, inc_reg, width_reg, height_reg;

    assign o_pending = result_queue.size();

    // Arithmetic shift that rounds toward minus infinity.
    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    // Cosine and sine of a binary angle by folded CORDIC.
    function automatic void cordic_cos_sin(input logic [15:0] ang,
                                           output longint c, output longint s);
        longint a, x, y, dx, dy;
        bit flip;
        a = longint'($signed(ang));
        flip = 0;
        x = 19898;
        y = 0;
        if (a > 16384) begin
            a -= 32768;
            flip = 1;
        end else if (a < -16384) begin
            a += 32768;
            flip = 1;
        end
        for (int i = 0; i < 14; i++) begin
            dx = floor_shift(y, i);
            dy = floor_shift(x, i);
            if (a >= 0) begin
                x -= dx;
                y += dy;
                a -= longint'(atan_turn(i[3:0]));
            end else begin
                x += dx;
                y -= dy;
                a += longint'(atan_turn(i[3:0]));
            end
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = (x > 32767) ? 32767 : (x < -32767) ? -32767 : x;
        s = (y > 32767) ? 32767 : (y < -32767) ? -32767 : y;
    endfunction

    // Nearest grid node, half away from zero; zero if outside.
    function automatic bit nearest_node(longint pos, logic [15:0] span, longint n,
                                        output longint node);
        longint num, q, sp;
        sp = longint'(span);
        node = 0;
        if (span == 0) return 0;
        num = pos * (n - 1);
        if (num >= 0) q = (2 * num + sp) / (2 * sp);
        else q = -((2 * (-num) + sp) / (2 * sp));
        if (q < 0 || q >= n) return 0;
        node = q;
        return 1;
    endfunction

    // Work out the result of one accepted beat and update the grid copy.
    function automatic t_grid_result predict_grid(logic [1:0] f, logic [15:0] range_mm,
            logic [10:0] step, logic [7:0] rx, logic [7:0] ry);
        t_grid_result r;
        logic [15:0] ang;
        longint c, s, px, py, gx, gy, k;
        r = '0;
        if (f == FUNC_CLEAR) begin
            foreach (occupancy[i]) occupancy[i] = '0;
        end else if (f == FUNC_READ) begin
            if (rx < GRID_X && ry < GRID_Y) r.value = occupancy[ry * GRID_X + rx];
        end else if (f == FUNC_SCAN) begin
            ang = start_reg + 16'(step * inc_reg);
            cordic_cos_sin(ang, c, s);
            px = longint'(pos_x_reg) + floor_shift(c * longint'(range_mm) + 16384, 15);
            py = longint'(pos_y_reg) + floor_shift(s * longint'(range_mm) + 16384, 15);
            if (nearest_node(px, width_reg, GRID_X, gx) &&
                    nearest_node(py, height_reg, GRID_Y, gy)) begin
                for (longint yy = gy - 1; yy <= gy + 1; yy++)
                    for (longint xx = gx - 1; xx <= gx + 1; xx++)
                        if (xx >= 0 && yy >= 0 && xx < GRID_X && yy < GRID_Y) begin
                            k = yy * GRID_X + xx;
                            occupancy[k] = 8'((int'(occupancy[k]) + 765) / 4);
                        end
                r.value = occupancy[gy * GRID_X + gx];
                r.hit = 1;
                r.nx = 8'(gx);
                r.ny = 8'(gy);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    // Track registers, predict on input beats, compare on output beats.
    always @(posedge i_clk) begin
        t_grid_result want;
        if (!i_rst_n) begin
            pos_x_reg = '0; pos_y_reg = '0; start_reg = '0; inc_reg = '0;
            width_reg = SPAN_RESET; height_reg = SPAN_RESET;
            foreach (occupancy[i]) occupancy[i] = '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_SENSOR_X: pos_x_reg = i_cfg_data;
                    REG_SENSOR_Y: pos_y_reg = i_cfg_data;
                    REG_START:    start_reg = i_cfg_data;
                    REG_INC:      inc_reg = i_cfg_data;
                    REG_WIDTH:    width_reg = i_cfg_data;
                    REG_HEIGHT:   height_reg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                result_queue = {result_queue, predict_grid(i_func, i_distance_mm,
                                i_step_index, i_read_x, i_read_y)};
            if (i_out_valid && !i_out_stall) begin
                if (result_queue.size() == 0) begin
                    report_mismatch("result beats beyond expected", 1, 0);
                end else begin
                    want = result_queue.pop_front();
                    if (i_in_grid) o_hits++;
                    if (i_cell_value !== want.value)
                        report_mismatch("cell_value", i_cell_value, want.value);
                    if (i_in_grid !== want.hit) report_mismatch("in_grid", i_in_grid, want.hit);
                    if (i_node_x !== want.nx) report_mismatch("node_x", i_node_x, want.nx);
                    if (i_node_y !== want.ny) report_mismatch("node_y", i_node_y, want.ny);
                end
            end
        end
    end

    initial begin
        o_errors = 0;
        o_hits = 0;
    end
endmodule

### tb/testbench.sv
// Stimulus and verdict for the occupancy grid unit.
module testbench import rsog_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0, i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 0, i_out_stall = 0;
    logic [1:0]  i_func = '0;
    logic [15:0] i_distance_mm = '0;
    logic [10:0] i_step_index = '0;
    logic [7:0]  i_read_x = '0, i_read_y = '0;
    logic        o_in_stall, o_out_valid, o_in_grid;
    logic [7:0]  o_cell_value, o_node_x, o_node_y;
    int          mismatch_count, results_pending, grid_hits;
    int          send_idle_pct = 0, stall_pct = 0, beats_sent = 0;

    range_scan_occupancy_grid_unit u_top (.*);

    occupancy_grid_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_in_valid, .i_in_stall(o_in_stall), .i_func, .i_distance_mm, .i_step_index,
        .i_read_x, .i_read_y, .i_out_valid(o_out_valid), .i_out_stall,
        .i_cell_value(o_cell_value), .i_in_grid(o_in_grid), .i_node_x(o_node_x),
        .i_node_y(o_node_y), .o_errors(mismatch_count), .o_pending(results_pending),
        .o_hits(grid_hits)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Random receiver stalls.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    // Send one beat, with random idle cycles ahead of it.
    task automatic send_beat(logic [1:0] f, logic [15:0] d, logic [10:0] s,
                             logic [7:0] rx, logic [7:0] ry);
        while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        i_in_valid <= 1;
        i_func <= f;
        i_distance_mm <= d;
        i_step_index <= s;
        i_read_x <= rx;
        i_read_y <= ry;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        i_in_valid <= 0;
        beats_sent++;
        // The unit is busy for at least this cycle after taking a beat.
        @(posedge i_clk);
    endtask

    // Wait for the unit to drain, then let a clear or scan finish in the back.
    task automatic drain_unit();
        while (results_pending != 0) @(posedge i_clk);
        repeat (5000) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        i_cfg_we <= 1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
    endtask

    // Mostly scan points at ranges that land in the grid, with reads, unused codes and rare clears.
    task automatic random_beat();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
            send_beat(FUNC_SCAN, (pick < 60) ? 16'($urandom_range(2000)) : 16'($urandom),
                      11'($urandom), 8'($urandom), 8'($urandom));
        else if (pick < 95)
            send_beat(FUNC_READ, 16'($urandom), 11'($urandom),
                      (pick < 90) ? 8'($urandom_range(63)) : 8'($urandom),
                      (pick < 90) ? 8'($urandom_range(63)) : 8'($urandom));
        else if (pick < 97)
            send_beat(2'd3, 16'($urandom), 11'($urandom), 8'($urandom), 8'($urandom));
        else
            send_beat(FUNC_CLEAR, 16'($urandom), 11'($urandom), 8'($urandom), 8'($urandom));
    endtask

    initial begin
        int idle_mix[4][2] = '{'{0, 0}, '{83, 0}, '{0, 83}, '{28, 28}};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;

        // Directed: reset settings, extreme fields, every function code.
        send_beat(FUNC_SCAN, 16'd0, 11'd0, 8'd0, 8'd0);
        send_beat(FUNC_SCAN, 16'd500, 11'd0, 8'd0, 8'd0);
        send_beat(FUNC_SCAN, 16'hFFFF, 11'h7FF, 8'hFF, 8'hFF);
        send_beat(FUNC_READ, 16'hFFFF, 11'h7FF, 8'd0, 8'd0);
        send_beat(FUNC_READ, 16'd0, 11'd0, 8'd1, 8'd1);
        send_beat(FUNC_READ, 16'd0, 11'd0, 8'd8, 8'd0);
        send_beat(FUNC_READ, 16'd0, 11'd0, 8'hFF, 8'd0);
        send_beat(FUNC_READ, 16'd0, 11'd0, 8'd0, 8'hFF);
        send_beat(2'd3, 16'hFFFF, 11'h7FF, 8'hFF, 8'hFF);
        send_beat(FUNC_CLEAR, 16'd0, 11'd0, 8'd0, 8'd0);
        send_beat(FUNC_READ, 16'd0, 11'd0, 8'd0, 8'd0);
        drain_unit();

        // Sensor in the grid center, quarter-turn steps, so folding is covered.
        write_reg(REG_SENSOR_X, 16'd500);
        write_reg(REG_SENSOR_Y, 16'd500);
        write_reg(REG_START, 16'h8000);
        write_reg(REG_INC, 16'h4000);
        for (int i = 0; i < 6; i++) send_beat(FUNC_SCAN, 16'd400, 11'(i), 8'd0, 8'd0);
        send_beat(FUNC_READ, 16'd0, 11'd0, 8'd32, 8'd32);
        drain_unit();

        // Zero spans never land; then extreme positions and spans.
        write_reg(REG_WIDTH, 16'd0);
        send_beat(FUNC_SCAN, 16'd0, 11'd0, 8'd0, 8'd0);
        drain_unit();
        write_reg(REG_WIDTH, 16'hFFFF);
        write_reg(REG_HEIGHT, 16'd0);
        send_beat(FUNC_SCAN, 16'd0, 11'd0, 8'd0, 8'd0);
        drain_unit();
        write_reg(REG_SENSOR_X, 16'h7FFF);
        write_reg(REG_SENSOR_Y, 16'h8000);
        write_reg(REG_HEIGHT, 16'hFFFF);
        write_reg(REG_INC, 16'hFFFF);
        send_beat(FUNC_SCAN, 16'hFFFF, 11'h7FF, 8'd0, 8'd0);
        send_beat(FUNC_SCAN, 16'd1, 11'd1, 8'd0, 8'd0);
        drain_unit();

        // Random phases, each with its own sensor setup and one of four idling mixes.
        for (int ph = 0; ph < 8; ph++) begin
            drain_unit();
            send_idle_pct = idle_mix[ph % 4][0];
            stall_pct = idle_mix[ph % 4][1];
            write_reg(REG_SENSOR_X, 16'($urandom_range(1000)));
            write_reg(REG_SENSOR_Y, 16'($urandom_range(1000)));
            write_reg(REG_START, 16'($urandom));
            write_reg(REG_INC, (ph == 7) ? 16'hFFFF : 16'($urandom_range(600)));
            write_reg(REG_WIDTH, (ph == 6) ? 16'd1 : 16'($urandom_range(800, 2000)));
            write_reg(REG_HEIGHT, 16'($urandom_range(800, 2000)));
            for (int n = 0; n < 125; n++) begin
                random_beat();
                if (n == 60) drain_unit();
            end
        end

        drain_unit();
        $display("Sent %0d beats over several sensor setups; %0d scan points landed.",
                 beats_sent, grid_hits);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
